[hw/rtl/grc_pkg.sv]
// Shared types, register codes and reset values for the gyro rate conditioner.
package grc_pkg;

    localparam int RATE_W   = 16;
    localparam int ACC_W    = 24;
    localparam int FRAC_W   = 8;
    localparam int CNT_W    = 4;
    localparam int THR_W    = 12;
    localparam int WGT_W    = 9;
    localparam int RPM_W    = 13;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 12;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_SEL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EMA_WEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_THR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_THR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_LIMIT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_FLR  = 3'd6;

    // axis select codes
    localparam logic [1:0] AXIS_AUTO = 2'd0;
    localparam logic [1:0] AXIS_X    = 2'd1;
    localparam logic [1:0] AXIS_Y    = 2'd2;
    localparam logic [1:0] AXIS_Z    = 2'd3;

    // reset values
    localparam logic [1:0]       RST_AXIS_SEL   = AXIS_Z;
    localparam logic [WGT_W-1:0] RST_EMA_WEIGHT = 9'd64;
    localparam logic [THR_W-1:0] RST_DEAD_BAND  = 12'd48;
    localparam logic [THR_W-1:0] RST_DIR_THR    = 12'd58;
    localparam logic [THR_W-1:0] RST_MOVE_THR   = 12'd58;
    localparam logic [CNT_W-1:0] RST_STOP_LIMIT = 4'd3;
    localparam logic [THR_W-1:0] RST_BRAKE_FLR  = 12'd16;

    localparam logic [WGT_W-1:0] WEIGHT_ONE = 9'd256;
    localparam logic [CNT_W-1:0] CNT_MAX    = 4'd15;
    // floor(x/6) == (x * RECIP6) >> 18 for all x below 2^17
    localparam logic [15:0]      RECIP6     = 16'd43691;

    typedef struct packed {
        logic [1:0]       axis_sel;
        logic [WGT_W-1:0] ema_weight;
        logic [THR_W-1:0] dead_band;
        logic [THR_W-1:0] dir_thr;
        logic [THR_W-1:0] move_thr;
        logic [CNT_W-1:0] stop_limit;
        logic [THR_W-1:0] brake_floor;
    } t_cfg;

    typedef struct packed {
        logic              zero;
        logic [RATE_W-1:0] rate;
        logic [RATE_W-1:0] mag;
    } t_sel;

    typedef struct packed {
        logic [RATE_W-1:0] raw_mag;
        logic [RATE_W-1:0] srate;
        logic [RATE_W-1:0] smag;
        logic [RPM_W-1:0]  rpm;
        logic              cw;
        logic              moving;
    } t_res;

    function automatic logic [RATE_W:0] abs16(input logic [RATE_W-1:0] v);
        logic signed [RATE_W:0] e;
        e = $signed({v[RATE_W-1], v});
        return e[RATE_W] ? (RATE_W+1)'(-e) : (RATE_W+1)'(e);
    endfunction

endpackage

[hw/rtl/grc_axis_select.sv]
// Axis choice (fixed or largest magnitude) followed by the symmetric deadband.
module grc_axis_select (
    input  logic [15:0]       i_rate_x,
    input  logic [15:0]       i_rate_y,
    input  logic [15:0]       i_rate_z,
    input  grc_pkg::t_cfg     i_cfg,
    output grc_pkg::t_sel     o_sel
);

    logic [16:0] ax, ay, az, mag;
    logic [15:0] rate;
    logic        zero;

    always_comb begin
        ax = grc_pkg::abs16(i_rate_x);
        ay = grc_pkg::abs16(i_rate_y);
        az = grc_pkg::abs16(i_rate_z);
        case (i_cfg.axis_sel)
            grc_pkg::AXIS_X: rate = i_rate_x;
            grc_pkg::AXIS_Y: rate = i_rate_y;
            grc_pkg::AXIS_Z: rate = i_rate_z;
            grc_pkg::AXIS_AUTO: begin
                // ties: Z wins, then X, then Y
                if (az >= ax && az >= ay)
                    rate = i_rate_z;
                else if (ax >= ay)
                    rate = i_rate_x;
                else
                    rate = i_rate_y;
            end
            default: rate = i_rate_z;
        endcase
        mag  = grc_pkg::abs16(rate);
        zero = (mag < {5'd0, i_cfg.dead_band}) || (mag == 17'd0);
        o_sel.zero = zero;
        o_sel.rate = rate;
        o_sel.mag  = zero ? 16'd0 : mag[15:0];
    end

endmodule

[hw/rtl/grc_state_stage.sv]
// Accumulator and zero-frame counter: EMA on live rates, halving and brake on zero.
module grc_state_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  grc_pkg::t_sel        i_sel,
    input  grc_pkg::t_cfg        i_cfg,
    output logic signed [23:0]   o_acc,
    output logic [15:0]          o_mag
);

    logic signed [23:0] r_acc, n_acc;
    logic [3:0]         r_cnt, n_cnt;
    logic [15:0]        r_mag;

    logic [3:0]         cnt_inc;
    logic signed [23:0] half_sum, half;
    logic [23:0]        half_abs;
    logic               brake;
    logic [8:0]         w, wc;
    logic signed [25:0] p1;
    logic signed [33:0] p2, p2_sh;
    logic [25:0]        sum;

    always_comb begin
        cnt_inc  = (r_cnt == grc_pkg::CNT_MAX) ? r_cnt : r_cnt + 4'd1;
        // divide by two, truncating toward zero
        half_sum = r_acc + $signed({23'd0, r_acc[23]});
        half     = half_sum >>> 1;
        half_abs = half[23] ? 24'(-half) : 24'(half);
        brake    = (cnt_inc >= i_cfg.stop_limit) ||
                   (half_abs < {4'd0, i_cfg.brake_floor, 8'd0});

        w     = (i_cfg.ema_weight > grc_pkg::WEIGHT_ONE) ? grc_pkg::WEIGHT_ONE
                                                         : i_cfg.ema_weight;
        wc    = grc_pkg::WEIGHT_ONE - w;
        // floor((w*rate*256 + wc*acc)/256) = w*rate + (wc*acc >>> 8)
        p1    = $signed({1'b0, w}) * $signed(i_sel.rate);
        p2    = $signed({1'b0, wc}) * r_acc;
        p2_sh = p2 >>> 8;
        sum   = p1 + p2_sh[25:0];

        if (i_sel.zero) begin
            n_cnt = cnt_inc;
            n_acc = brake ? 24'sd0 : half;
        end else begin
            n_cnt = 4'd0;
            n_acc = $signed(sum[23:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= 24'sd0;
            r_cnt <= 4'd0;
        end else if (i_en) begin
            r_acc <= n_acc;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag <= i_sel.mag;
        end
    end

    assign o_acc = r_acc;
    assign o_mag = r_mag;

endmodule

[hw/rtl/grc_result_stage.sv]
// Direction hysteresis and the result register: magnitudes, rpm and moving flag.
module grc_result_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic signed [23:0]   i_acc,
    input  logic [15:0]          i_mag,
    input  grc_pkg::t_cfg        i_cfg,
    output grc_pkg::t_res        o_res
);

    logic               r_dir, n_dir;
    grc_pkg::t_res      r_res, n_res;

    logic signed [23:0] dthr;
    logic [23:0]        amag;
    logic [15:0]        smag;
    logic [31:0]        rpm_prod;

    always_comb begin
        dthr = $signed({4'd0, i_cfg.dir_thr, 8'd0});
        if (i_acc > dthr)
            n_dir = 1'b0;
        else if (i_acc < -dthr)
            n_dir = 1'b1;
        else
            n_dir = r_dir;

        amag     = i_acc[23] ? 24'(-i_acc) : 24'(i_acc);
        smag     = amag[23:8];
        rpm_prod = smag * grc_pkg::RECIP6;

        n_res.raw_mag = i_mag;
        n_res.smag    = smag;
        n_res.srate   = i_acc[23] ? 16'(-smag) : smag;
        n_res.rpm     = rpm_prod[30:18];
        n_res.cw      = n_dir;
        n_res.moving  = amag > {4'd0, i_cfg.move_thr, 8'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= 1'b0;
        end else if (i_en) begin
            r_dir <= n_dir;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

[hw/rtl/gyro_rotation_rate_conditioner.sv]
// Top level of the gyro rotation-rate conditioner.
// One three-axis sample per transaction, one result per sample. The block takes a
// transaction every cycle while o_in_stall is low; each sample is loaded into the
// input register at the accepting edge, then into the accumulator stage, then into
// the result register. The accumulator update is what sets that one-per-cycle
// figure. A stalled output only holds the stages behind it once they are full.
// Configuration writes take effect at once and should be made while no
// transaction is in flight.
module gyro_rotation_rate_conditioner (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [15:0]        i_rate_x,
    input  logic [15:0]        i_rate_y,
    input  logic [15:0]        i_rate_z,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [15:0]        o_raw_magnitude,
    output logic signed [15:0] o_smoothed_rate,
    output logic [15:0]        o_smoothed_magnitude,
    output logic [12:0]        o_speed_rpm,
    output logic               o_is_clockwise,
    output logic               o_is_moving,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [11:0]        i_cfg_data
);

    grc_pkg::t_cfg      r_cfg;
    logic [15:0]        r_rate_x, r_rate_y, r_rate_z;
    logic               r_a_vld, r_b_vld, r_c_vld;
    logic               a_ready, b_ready, c_ready;
    logic               in_take, move_ab, move_bc;
    grc_pkg::t_sel      sel;
    grc_pkg::t_res      res;
    logic signed [23:0] acc;
    logic [15:0]        mag;

    always_comb begin
        c_ready = !r_c_vld || !i_out_stall;
        b_ready = !r_b_vld || c_ready;
        a_ready = !r_a_vld || b_ready;
        in_take = i_in_valid && a_ready;
        move_ab = r_a_vld && b_ready;
        move_bc = r_b_vld && c_ready;
    end

    assign o_in_stall = !a_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            if (a_ready) r_a_vld <= i_in_valid;
            if (b_ready) r_b_vld <= r_a_vld;
            if (c_ready) r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_rate_x <= i_rate_x;
            r_rate_y <= i_rate_y;
            r_rate_z <= i_rate_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.axis_sel    <= grc_pkg::RST_AXIS_SEL;
            r_cfg.ema_weight  <= grc_pkg::RST_EMA_WEIGHT;
            r_cfg.dead_band   <= grc_pkg::RST_DEAD_BAND;
            r_cfg.dir_thr     <= grc_pkg::RST_DIR_THR;
            r_cfg.move_thr    <= grc_pkg::RST_MOVE_THR;
            r_cfg.stop_limit  <= grc_pkg::RST_STOP_LIMIT;
            r_cfg.brake_floor <= grc_pkg::RST_BRAKE_FLR;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                grc_pkg::CFG_AXIS_SEL:   r_cfg.axis_sel    <= i_cfg_data[1:0];
                grc_pkg::CFG_EMA_WEIGHT: r_cfg.ema_weight  <= i_cfg_data[8:0];
                grc_pkg::CFG_DEAD_BAND:  r_cfg.dead_band   <= i_cfg_data;
                grc_pkg::CFG_DIR_THR:    r_cfg.dir_thr     <= i_cfg_data;
                grc_pkg::CFG_MOVE_THR:   r_cfg.move_thr    <= i_cfg_data;
                grc_pkg::CFG_STOP_LIMIT: r_cfg.stop_limit  <= i_cfg_data[3:0];
                grc_pkg::CFG_BRAKE_FLR:  r_cfg.brake_floor <= i_cfg_data;
                default: ;
            endcase
        end
    end

    grc_axis_select u_axis (
        .i_rate_x (r_rate_x),
        .i_rate_y (r_rate_y),
        .i_rate_z (r_rate_z),
        .i_cfg    (r_cfg),
        .o_sel    (sel)
    );

    grc_state_stage u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (move_ab),
        .i_sel   (sel),
        .i_cfg   (r_cfg),
        .o_acc   (acc),
        .o_mag   (mag)
    );

    grc_result_stage u_result (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (move_bc),
        .i_acc   (acc),
        .i_mag   (mag),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    assign o_out_valid          = r_c_vld;
    assign o_raw_magnitude      = res.raw_mag;
    assign o_smoothed_rate      = $signed(res.srate);
    assign o_smoothed_magnitude = res.smag;
    assign o_speed_rpm          = res.rpm;
    assign o_is_clockwise       = res.cw;
    assign o_is_moving          = res.moving;

endmodule

[hw/rtl/grc_checker.sv]
// Port-level checks for the gyro rate conditioner and their bind to the top level.
module grc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [15:0]        o_raw_magnitude,
    input logic signed [15:0] o_smoothed_rate,
    input logic [15:0]        o_smoothed_magnitude,
    input logic [12:0]        o_speed_rpm
);

    logic [16:0] rpm_x6;

    assign rpm_x6 = {4'd0, o_speed_rpm} * 17'd6;

    // a stalled transaction stays on the port
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_raw_magnitude) &&
                                      $stable(o_smoothed_rate))
        else $error("stalled result changed");

    // signed rate and its magnitude must agree
    a_sign_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_smoothed_rate == $signed(o_smoothed_magnitude)) ||
                        (o_smoothed_rate == $signed(16'(~o_smoothed_magnitude + 16'd1))))
        else $error("smoothed rate and magnitude disagree");

    // rpm is the magnitude over six, rounded down
    a_rpm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (rpm_x6 <= {1'b0, o_smoothed_magnitude}) &&
                        ({1'b0, o_smoothed_magnitude} < rpm_x6 + 17'd6))
        else $error("speed_rpm is not magnitude / 6");

endmodule

bind gyro_rotation_rate_conditioner grc_checker u_grc_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .o_out_valid          (o_out_valid),
    .i_out_stall          (i_out_stall),
    .o_raw_magnitude      (o_raw_magnitude),
    .o_smoothed_rate      (o_smoothed_rate),
    .o_smoothed_magnitude (o_smoothed_magnitude),
    .o_speed_rpm          (o_speed_rpm)
);
